### rtl/core/qsvh_pkg.sv
// ----------------------------------------------------------------------------
// qsvh_pkg
// Shared widths, register indexes and types of the q-ary spin value histogram.
// ----------------------------------------------------------------------------
package qsvh_pkg;

   localparam int PLANE_W    = 64;
   localparam int NUM_PLANES = 4;
   localparam int MULT_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int BIN_W      = 4;
   localparam int Q_W        = 5;
   localparam int HIST_DEPTH = 16;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   localparam int REQ_W = NUM_PLANES * PLANE_W + MULT_W;
   localparam int RSP_W = ((BIN_W + COUNT_W + 7) / 8) * 8;

   localparam logic [REG_IDX_W-1:0] REG_MODULUS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_OP_PLANE_0 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OP_PLANE_1 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OP_PLANE_2 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OP_PLANE_3 = 3'd4;

   typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_set_type;

   // one datapoint leaving the spin value pipeline
   typedef struct packed {
      logic              valid;
      logic [BIN_W-1:0]  bin;
      logic [MULT_W-1:0] mult;
      logic              last;
   } point_type;

endpackage

### rtl/core/qsvh_spin_calc.sv
// ----------------------------------------------------------------------------
// qsvh_spin_calc
// Six-stage pipeline: masked plane popcounts, weighted sum over plane pairs,
// then the sum reduced modulo q by restoring steps over two stages.
// ----------------------------------------------------------------------------
module qsvh_spin_calc #(
   parameter int NUM_VARS   = 64,
   parameter int MAX_PLANES = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  qsvh_pkg::plane_set_type        state_planes,
   input  qsvh_pkg::plane_set_type        op_planes,
   input  logic [qsvh_pkg::MULT_W-1:0]    in_mult,
   input  logic                           in_last,
   input  logic [qsvh_pkg::Q_W-1:0]       q_eff,
   output qsvh_pkg::point_type            pt
);

   localparam int NUM_BYTES  = (NUM_VARS + 7) / 8;
   localparam int NUM_PAIRS  = MAX_PLANES * MAX_PLANES;
   localparam int BYTE_CNT_W = 4;
   localparam int CNT_W      = $clog2(NUM_VARS + 1);
   localparam int ROW_W      = CNT_W + MAX_PLANES;
   localparam int SUM_W      = CNT_W + 2 * MAX_PLANES;
   localparam int LO_W       = SUM_W / 2;
   localparam int STAGES     = 6;

   localparam int QW = qsvh_pkg::Q_W;

   logic [BYTE_CNT_W-1:0]       byte_cnt_in [NUM_PAIRS][NUM_BYTES];
   logic [BYTE_CNT_W-1:0]       byte_cnt_ff [NUM_PAIRS][NUM_BYTES];
   logic [CNT_W-1:0]            pair_cnt_in [NUM_PAIRS];
   logic [CNT_W-1:0]            pair_cnt_ff [NUM_PAIRS];
   logic [ROW_W-1:0]            row_in [MAX_PLANES];
   logic [ROW_W-1:0]            row_ff [MAX_PLANES];
   logic [SUM_W-1:0]            sum_in;
   logic [SUM_W-1:0]            sum_ff;
   logic [QW-1:0]               rem_hi_in;
   logic [QW-1:0]               rem_hi_ff;
   logic [LO_W-1:0]             lo_in;
   logic [LO_W-1:0]             lo_ff;
   logic [QW-1:0]               rem_in;
   logic [QW-1:0]               rem_ff;

   logic [STAGES-1:0]           valid_in;
   logic [STAGES-1:0]           valid_ff;
   logic [STAGES-1:0]           last_in;
   logic [STAGES-1:0]           last_ff;
   logic [qsvh_pkg::MULT_W-1:0] mult_in [STAGES];
   logic [qsvh_pkg::MULT_W-1:0] mult_ff [STAGES];

   // stage 1: popcount of each byte of every state/op plane pair
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         for (int b = 0; b < NUM_BYTES; b++) begin
            byte_cnt_in[p][b] = '0;
            for (int k = 0; k < 8; k++) begin
               if (b * 8 + k < NUM_VARS) begin
                  byte_cnt_in[p][b] = byte_cnt_in[p][b] + BYTE_CNT_W'(
                     state_planes[p / MAX_PLANES][b * 8 + k] &
                     op_planes[p % MAX_PLANES][b * 8 + k]);
               end
            end
         end
      end
   end

   // stage 2: per-pair count
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         pair_cnt_in[p] = '0;
         for (int b = 0; b < NUM_BYTES; b++) begin
            pair_cnt_in[p] = pair_cnt_in[p] + CNT_W'(byte_cnt_ff[p][b]);
         end
      end
   end

   // stage 3: weight by op plane
   always_comb begin
      for (int i = 0; i < MAX_PLANES; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < MAX_PLANES; j++) begin
            row_in[i] = row_in[i] + (ROW_W'(pair_cnt_ff[i * MAX_PLANES + j]) << j);
         end
      end
   end

   // stage 4: weight by state plane
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_PLANES; i++) begin
         sum_in = sum_in + (SUM_W'(row_ff[i]) << i);
      end
   end

   // stage 5: restoring reduction of the upper bits
   always_comb begin
      rem_hi_in = '0;
      for (int k = SUM_W - 1; k >= LO_W; k--) begin
         rem_hi_in = {rem_hi_in[QW-2:0], sum_ff[k]};
         if (rem_hi_in >= q_eff) begin
            rem_hi_in = rem_hi_in - q_eff;
         end
      end
      lo_in = sum_ff[LO_W-1:0];
   end

   // stage 6: finish with the lower bits
   always_comb begin
      rem_in = rem_hi_ff;
      for (int k = LO_W - 1; k >= 0; k--) begin
         rem_in = {rem_in[QW-2:0], lo_ff[k]};
         if (rem_in >= q_eff) begin
            rem_in = rem_in - q_eff;
         end
      end
   end

   always_comb begin
      valid_in   = {valid_ff[STAGES-2:0], in_valid};
      last_in    = {last_ff[STAGES-2:0], in_last};
      mult_in[0] = in_mult;
      for (int s = 1; s < STAGES; s++) begin
         mult_in[s] = mult_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_cnt_ff <= byte_cnt_in;
      pair_cnt_ff <= pair_cnt_in;
      row_ff      <= row_in;
      sum_ff      <= sum_in;
      rem_hi_ff   <= rem_hi_in;
      lo_ff       <= lo_in;
      rem_ff      <= rem_in;
      last_ff     <= last_in;
      mult_ff     <= mult_in;
   end

   assign pt.valid = valid_ff[STAGES-1];
   assign pt.bin   = rem_ff[qsvh_pkg::BIN_W-1:0];
   assign pt.mult  = mult_ff[STAGES-1];
   assign pt.last  = last_ff[STAGES-1];

endmodule

### rtl/core/qary_spin_value_histogram.sv
// ----------------------------------------------------------------------------
// qary_spin_value_histogram
// Histogram of operator spin values modulo q over a run of weighted points.
// ----------------------------------------------------------------------------
// A point that is not the last of its run is taken every cycle. Its spin value
// passes a six-stage popcount and modulo pipeline, then a two-stage
// read-modify-write of the 16-entry histogram memory, with forwarding between
// back-to-back hits on one bin. The point marked last closes the run: input is
// held off after it while the pipeline drains and while the q bins are read
// out, each in a read state and a load state, through the memory's single
// registered read port, and longer when the result side stalls. The histogram
// is cleared at once after the last bin, and after reset, by per-bin valid
// flags; no clearing pass is needed. Registers sit at byte address 8*i:
// modulus, then operator planes 0..3.
module qary_spin_value_histogram #(
   parameter int NUM_VARS   = 64,
   parameter int MAX_PLANES = 4,
   parameter int MAX_Q      = 16
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // state_plane_0, state_plane_1, state_plane_2, state_plane_3, multiplicity
   input  logic [qsvh_pkg::REQ_W-1:0]       req_tdata,
   input  logic                             req_tlast,   // last_point

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // bin_index, bin_count, zero pad
   output logic [qsvh_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,   // last_bin

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [qsvh_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [qsvh_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [qsvh_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int QW  = qsvh_pkg::Q_W;
   localparam int BW  = qsvh_pkg::BIN_W;
   localparam int CW  = qsvh_pkg::COUNT_W;
   localparam int MW  = qsvh_pkg::MULT_W;
   localparam int PAD = qsvh_pkg::RSP_W - BW - CW;

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   // configuration
   logic [QW-1:0]                      modulus_ff, modulus_in;
   qsvh_pkg::plane_set_type            op_plane_ff, op_plane_in;
   logic                               csr_wr;
   logic [qsvh_pkg::REG_IDX_W-1:0]     csr_idx;
   logic [QW-1:0]                      q_eff;
   logic [QW-1:0]                      q_last;

   // input side
   logic                               req_accept;
   qsvh_pkg::plane_set_type            req_planes;
   logic [MW-1:0]                      req_mult;
   qsvh_pkg::point_type                pt;

   // histogram update
   qsvh_pkg::point_type                m1_ff, m1_in;
   logic [CW-1:0]                      hist_mem [qsvh_pkg::HIST_DEPTH];
   logic [CW-1:0]                      mem_q_ff;
   logic [qsvh_pkg::HIST_DEPTH-1:0]    bin_vld_ff, bin_vld_in;
   logic                               rd_vld_ff;
   logic [BW-1:0]                      rd_addr;
   logic                               wr_en;
   logic [CW-1:0]                      old_count;
   logic [CW:0]                        sum_count;
   logic [CW-1:0]                      new_count;
   logic                               fwd_valid_ff, fwd_valid_in;
   logic [BW-1:0]                      fwd_bin_ff, fwd_bin_in;
   logic [CW-1:0]                      fwd_count_ff, fwd_count_in;
   logic                               fwd_hit;
   logic [CW-1:0]                      read_count;

   // readout control
   state_type                          state_ff, state_in;
   logic [BW-1:0]                      idx_ff, idx_in;
   logic                               busy_ff, busy_in;
   logic                               out_free;
   logic                               load;
   logic                               clear;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                      rsp_index_ff, rsp_index_in;
   logic [CW-1:0]                      rsp_count_ff, rsp_count_in;
   logic                               rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[qsvh_pkg::CSR_ADDR_W-1:3];

   always_comb begin
      modulus_in  = modulus_ff;
      op_plane_in = op_plane_ff;
      if (csr_wr) begin
         case (csr_idx)
            qsvh_pkg::REG_MODULUS:    modulus_in     = csr_pwdata[QW-1:0];
            qsvh_pkg::REG_OP_PLANE_0: op_plane_in[0] = csr_pwdata;
            qsvh_pkg::REG_OP_PLANE_1: op_plane_in[1] = csr_pwdata;
            qsvh_pkg::REG_OP_PLANE_2: op_plane_in[2] = csr_pwdata;
            qsvh_pkg::REG_OP_PLANE_3: op_plane_in[3] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= QW'(2);
         op_plane_ff <= '0;
      end else begin
         modulus_ff  <= modulus_in;
         op_plane_ff <= op_plane_in;
      end
   end

   always_comb begin
      case (csr_idx)
         qsvh_pkg::REG_MODULUS:    csr_prdata = qsvh_pkg::CSR_DATA_W'(modulus_ff);
         qsvh_pkg::REG_OP_PLANE_0: csr_prdata = op_plane_ff[0];
         qsvh_pkg::REG_OP_PLANE_1: csr_prdata = op_plane_ff[1];
         qsvh_pkg::REG_OP_PLANE_2: csr_prdata = op_plane_ff[2];
         qsvh_pkg::REG_OP_PLANE_3: csr_prdata = op_plane_ff[3];
         default:                  csr_prdata = '0;
      endcase
   end

   // clamp the modulus to 2..MAX_Q
   always_comb begin
      if (modulus_ff < QW'(2)) begin
         q_eff = QW'(2);
      end else if (modulus_ff > QW'(MAX_Q)) begin
         q_eff = QW'(MAX_Q);
      end else begin
         q_eff = modulus_ff;
      end
   end

   assign q_last = q_eff - QW'(1);

   // ------------------------------------------------------------- spin value
   assign req_tready = ~busy_ff;
   assign req_accept = req_tvalid & req_tready;
   assign req_planes = req_tdata[qsvh_pkg::NUM_PLANES*qsvh_pkg::PLANE_W-1:0];
   assign req_mult   = req_tdata[qsvh_pkg::NUM_PLANES*qsvh_pkg::PLANE_W +: MW];

   qsvh_spin_calc #(
      .NUM_VARS   (NUM_VARS),
      .MAX_PLANES (MAX_PLANES)
   ) u_spin_calc (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_accept),
      .state_planes (req_planes),
      .op_planes    (op_plane_ff),
      .in_mult      (req_mult),
      .in_last      (req_tlast),
      .q_eff        (q_eff),
      .pt           (pt)
   );

   // ------------------------------------------------------ histogram update
   assign m1_in   = pt;
   // hold the readout address for the whole read and load of a bin
   assign rd_addr = (state_ff == ST_RUN) ? pt.bin : idx_ff;
   assign wr_en   = m1_ff.valid;

   // the write issued in the read cycle is not in mem_q_ff: take it from fwd
   assign fwd_hit    = fwd_valid_ff && (fwd_bin_ff == m1_ff.bin);
   assign read_count = rd_vld_ff ? mem_q_ff : '0;
   assign old_count  = fwd_hit ? fwd_count_ff : read_count;
   assign sum_count  = {1'b0, old_count} + {1'b0, m1_ff.mult};
   assign new_count  = sum_count[CW] ? {CW{1'b1}} : sum_count[CW-1:0];

   assign fwd_valid_in = wr_en;
   assign fwd_bin_in   = m1_ff.bin;
   assign fwd_count_in = new_count;

   always_comb begin
      bin_vld_in = bin_vld_ff;
      if (clear) begin
         bin_vld_in = '0;
      end else if (wr_en) begin
         bin_vld_in[m1_ff.bin] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[m1_ff.bin] <= new_count;
      end
      mem_q_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff        <= '0;
         bin_vld_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         m1_ff        <= m1_in;
         bin_vld_ff   <= bin_vld_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff    <= bin_vld_ff[rd_addr];
      fwd_bin_ff   <= fwd_bin_in;
      fwd_count_ff <= fwd_count_in;
   end

   // ---------------------------------------------------------------- readout
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      load     = 1'b0;
      clear    = 1'b0;
      if (req_accept && req_tlast) begin
         busy_in = 1'b1;
      end
      case (state_ff)
         ST_RUN: begin
            if (m1_ff.valid && m1_ff.last) begin
               state_in = ST_READ;
               idx_in   = '0;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               load = 1'b1;
               if (idx_ff == q_last[BW-1:0]) begin
                  clear    = 1'b1;
                  busy_in  = 1'b0;
                  state_in = ST_RUN;
               end else begin
                  idx_in   = idx_ff + BW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = idx_ff;
         rsp_count_in = read_count;
         rsp_last_in  = (idx_ff == q_last[BW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, rsp_count_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/core/qsvh_checker.sv
// ----------------------------------------------------------------------------
// qsvh_checker
// Port-level checks of the histogram readout, bound to the top level.
// ----------------------------------------------------------------------------
module qsvh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [qsvh_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // a closing point stops further input: ready falls right after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after the last point");

   // while bins are still to come, no new point enters
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken during histogram readout");

   // a result appears only out of a readout
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result word without a closed run");

endmodule

bind qary_spin_value_histogram qsvh_checker u_qsvh_checker (.*);
